// ===== hw/rtl/spdq_pkg.sv =====
// Shared types and codes for the stable priority dispatch queue.
package spdq_pkg;

	// Operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;
	localparam logic [1:0] STATUS_INACTIVE = 2'd3;

	// Severity levels held in the queue
	localparam int NUM_LEVELS = 3;

	// Reset value of the active destination register
	localparam logic [2:0] ACTIVE_DEST_RESET = 3'd2;

	typedef struct packed {
		logic        op;
		logic [1:0]  severity;
		logic [15:0] tag;
		logic [1:0]  destination;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_tag;
		logic [1:0]  out_severity;
		logic [1:0]  out_destination;
		logic [15:0] served_count;
		logic [1:0]  status;
		logic [5:0]  occupancy;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

endpackage

// ===== hw/rtl/stable_priority_dispatch_queue_top.sv =====
// Stable three-level priority dispatch queue: per-level ring buffers in one tag memory.
//
// Usage: present an item on item and raise start while busy is low; the item
// transfers at that clock edge. A push (op 0) files the tag behind all waiting
// items of the same or higher severity; a pop (op 1) removes the head item and
// hands it to item.destination, bumping that destination's served counter.
// Every item yields exactly one result: result_valid is high for one cycle
// with the result struct, and the receiver must take it in that cycle.
// A push or a refused pop has its result built in the execute state and
// registered; a successful pop also passes the read state, since the head tag
// is read from the synchronous tag memory.
// Busy stays high through the execute state and, after a successful pop, the
// read state, so a new item is taken only once the last has left them.
// Each level (severities 0 and 1 share the lowest) has its own ring in the tag
// memory with head and tail pointers; the head comes from the highest nonempty level.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) sets how many
// destinations are active; it is always ready.
// Reset clears all counts, pointers and served counters and sets two active
// destinations; the tag memory is not cleared and needs no sweep.
module stable_priority_dispatch_queue_top #(
	parameter int QUEUE_DEPTH      = 32,
	parameter int MAX_DESTINATIONS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  spdq_pkg::in_item_t   item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_data,
	output logic                 result_valid,
	output spdq_pkg::out_item_t  result
);

	localparam int PTR_W    = $clog2(QUEUE_DEPTH);
	localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W   = PTR_W + 2;
	localparam int MEM_SIZE = 4 << PTR_W;
	localparam int DST_W    = (MAX_DESTINATIONS > 1) ? $clog2(MAX_DESTINATIONS) : 1;

	// Control state
	spdq_pkg::state_t     state_q, state_d;
	logic [2:0]           active_q;
	logic [CNT_W-1:0]     total_q;
	logic [CNT_W-1:0]     lvl_cnt_q [spdq_pkg::NUM_LEVELS];
	logic [PTR_W-1:0]     head_q    [spdq_pkg::NUM_LEVELS];
	logic [PTR_W-1:0]     tail_q    [spdq_pkg::NUM_LEVELS];
	logic [15:0]          served_q  [MAX_DESTINATIONS];
	logic                 done_q;

	// Payload registers
	spdq_pkg::in_item_t   item_q;
	spdq_pkg::out_item_t  res_q;
	logic [15:0]          mem [MEM_SIZE];
	logic [15:0]          rd_data_s1;

	// Decoded controls
	logic                 accept;
	logic                 push_ok, push_full;
	logic                 pop_empty, pop_inactive, pop_ok;
	logic                 emit_now, emit_tag;
	logic [1:0]           push_lvl, head_lvl;
	logic [DST_W-1:0]     dst_idx;
	logic [15:0]          served_next;
	logic [CNT_W-1:0]     total_next;
	logic [CNT_W+5:0]     occ_ext;
	logic [ADDR_W-1:0]    wr_addr, rd_addr;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Level of the pushed item: severity zero counts as the lowest level
	always_comb begin
		case (item_q.severity)
			2'd3:    push_lvl = 2'd2;
			2'd2:    push_lvl = 2'd1;
			default: push_lvl = 2'd0;
		endcase
	end

	// Head sits in the highest nonempty level
	always_comb begin
		if (lvl_cnt_q[2] != '0) begin
			head_lvl = 2'd2;
		end else if (lvl_cnt_q[1] != '0) begin
			head_lvl = 2'd1;
		end else begin
			head_lvl = 2'd0;
		end
	end

	assign dst_idx     = DST_W'(item_q.destination);
	assign served_next = served_q[dst_idx] + 16'd1;
	assign wr_addr     = {push_lvl, tail_q[push_lvl]};
	assign rd_addr     = {head_lvl, head_q[head_lvl]};

	// Next state and per-state controls
	always_comb begin
		state_d      = state_q;
		busy         = 1'b1;
		push_ok      = 1'b0;
		push_full    = 1'b0;
		pop_empty    = 1'b0;
		pop_inactive = 1'b0;
		pop_ok       = 1'b0;
		emit_now     = 1'b0;
		emit_tag     = 1'b0;
		unique case (state_q)
			spdq_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = spdq_pkg::ST_EXEC;
				end
			end
			spdq_pkg::ST_EXEC: begin
				if (item_q.op == spdq_pkg::OP_PUSH) begin
					push_full = (total_q == CNT_W'(QUEUE_DEPTH));
					push_ok   = !push_full;
					emit_now  = 1'b1;
					state_d   = spdq_pkg::ST_IDLE;
				end else if (total_q == '0) begin
					pop_empty = 1'b1;
					emit_now  = 1'b1;
					state_d   = spdq_pkg::ST_IDLE;
				end else if (({1'b0, item_q.destination} >= active_q) ||
						(32'(item_q.destination) >= MAX_DESTINATIONS)) begin
					pop_inactive = 1'b1;
					emit_now     = 1'b1;
					state_d      = spdq_pkg::ST_IDLE;
				end else begin
					pop_ok  = 1'b1;
					state_d = spdq_pkg::ST_READ;
				end
			end
			spdq_pkg::ST_READ: begin
				emit_tag = 1'b1;
				state_d  = spdq_pkg::ST_IDLE;
			end
			default: begin
				state_d = spdq_pkg::ST_IDLE;
			end
		endcase
	end

	// Occupancy after this step, masked to the result width
	always_comb begin
		total_next = total_q;
		if (push_ok) begin
			total_next = total_q + CNT_W'(1);
		end else if (pop_ok) begin
			total_next = total_q - CNT_W'(1);
		end
	end
	assign occ_ext = {6'd0, total_next};

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spdq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= spdq_pkg::ACTIVE_DEST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	// Queue bookkeeping: counts and ring pointers per level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int i = 0; i < spdq_pkg::NUM_LEVELS; i++) begin
				lvl_cnt_q[i] <= '0;
				head_q[i]    <= '0;
				tail_q[i]    <= '0;
			end
		end else begin
			total_q <= total_next;
			if (push_ok) begin
				lvl_cnt_q[push_lvl] <= lvl_cnt_q[push_lvl] + CNT_W'(1);
				tail_q[push_lvl]    <= tail_q[push_lvl] + PTR_W'(1);
			end
			if (pop_ok) begin
				lvl_cnt_q[head_lvl] <= lvl_cnt_q[head_lvl] - CNT_W'(1);
				head_q[head_lvl]    <= head_q[head_lvl] + PTR_W'(1);
			end
		end
	end

	// Served counters per destination
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DESTINATIONS; i++) begin
				served_q[i] <= '0;
			end
		end else if (pop_ok) begin
			served_q[dst_idx] <= served_next;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit_now || emit_tag;
		end
	end

	// Capture the item on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	// Tag memory: write on push, read head on pop
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_addr] <= item_q.tag;
		end
		if (pop_ok) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Build the result; the popped tag lands in the following cycle, in the read state
	always_ff @(posedge clk) begin
		if (emit_now || pop_ok) begin
			res_q.out_tag         <= '0;
			res_q.out_severity    <= pop_ok ? (head_lvl + 2'd1) : 2'd0;
			res_q.out_destination <= (item_q.op == spdq_pkg::OP_POP) ?
				item_q.destination : 2'd0;
			res_q.served_count    <= pop_ok ? served_next : 16'd0;
			res_q.occupancy       <= occ_ext[5:0];
			if (push_full) begin
				res_q.status <= spdq_pkg::STATUS_FULL;
			end else if (pop_empty) begin
				res_q.status <= spdq_pkg::STATUS_EMPTY;
			end else if (pop_inactive) begin
				res_q.status <= spdq_pkg::STATUS_INACTIVE;
			end else begin
				res_q.status <= spdq_pkg::STATUS_OK;
			end
		end else if (emit_tag) begin
			res_q.out_tag <= rd_data_s1;
		end
	end

	assign result_valid = done_q;
	assign result       = res_q;

endmodule

// ===== tb/tb_stable_priority_dispatch_queue_top.sv =====
// Testbench for the stable priority dispatch queue: outcome tracker, drivers and checks.
module tb_stable_priority_dispatch_queue_top;

	localparam int QUEUE_SLOTS = 32;
	localparam int DEST_COUNT  = 4;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 240;

	// Mirror of the queue contents, served totals and active limit; predicts each outcome
	class dispatch_tracker;
		typedef struct {
			logic [15:0] tag;
			logic [1:0]  sev;
		} waiting_entry_t;

		waiting_entry_t           waiting_line[$];
		logic [15:0]              served_totals[DEST_COUNT];
		logic [2:0]               active_limit;
		spdq_pkg::out_item_t      pending_outcomes[$];
		int                       errors;

		function new();
			foreach (served_totals[i]) served_totals[i] = '0;
			active_limit = spdq_pkg::ACTIVE_DEST_RESET;
			errors = 0;
		endfunction

		function void set_active(logic [2:0] value);
			active_limit = value;
		endfunction

		function int pending();
			return pending_outcomes.size();
		endfunction

		// Apply one accepted request to the mirror and queue its outcome
		function void note_request(spdq_pkg::in_item_t req);
			spdq_pkg::out_item_t outcome;
			waiting_entry_t      entry;
			int                  pos;
			int                  usable;
			outcome = '0;
			if (req.op == spdq_pkg::OP_PUSH) begin
				if (waiting_line.size() >= QUEUE_SLOTS) begin
					outcome.status = spdq_pkg::STATUS_FULL;
				end else begin
					entry.tag = req.tag;
					// Saturate severity zero to the lowest level
					entry.sev = (req.severity == 2'd0) ? 2'd1 : req.severity;
					pos = 0;
					while (pos < waiting_line.size() && waiting_line[pos].sev >= entry.sev)
						pos++;
					waiting_line.insert(pos, entry);
					outcome.status = spdq_pkg::STATUS_OK;
				end
			end else begin
				outcome.out_destination = req.destination;
				usable = (active_limit > DEST_COUNT) ? DEST_COUNT : int'(active_limit);
				if (waiting_line.size() == 0) begin
					outcome.status = spdq_pkg::STATUS_EMPTY;
				end else if (req.destination >= usable) begin
					outcome.status = spdq_pkg::STATUS_INACTIVE;
				end else begin
					entry = waiting_line.pop_front();
					served_totals[req.destination] = served_totals[req.destination] + 16'd1;
					outcome.out_tag      = entry.tag;
					outcome.out_severity = entry.sev;
					outcome.served_count = served_totals[req.destination];
					outcome.status       = spdq_pkg::STATUS_OK;
				end
			end
			outcome.occupancy = 6'(waiting_line.size());
			pending_outcomes.push_back(outcome);
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		// Compare one delivered outcome with the oldest prediction
		function void check_outcome(spdq_pkg::out_item_t got);
			spdq_pkg::out_item_t want;
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected outcome, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_outcomes.pop_front();
			compare_field("out_tag", 32'(want.out_tag), 32'(got.out_tag));
			compare_field("out_severity", 32'(want.out_severity), 32'(got.out_severity));
			compare_field("out_destination", 32'(want.out_destination),
				32'(got.out_destination));
			compare_field("served_count", 32'(want.served_count), 32'(got.served_count));
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
		endfunction

		function void flag_leftovers();
			if (pending_outcomes.size() != 0) begin
				$display("%0t: missing outcomes, expected %0d more, actual 0", $time,
					pending_outcomes.size());
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	spdq_pkg::in_item_t   item;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [2:0]           cfg_data;
	logic                 result_valid;
	spdq_pkg::out_item_t  result;

	dispatch_tracker tracker = new();
	int gap_pct;
	int quiet_cycles;

	stable_priority_dispatch_queue_top #(
		.QUEUE_DEPTH      (QUEUE_SLOTS),
		.MAX_DESTINATIONS (DEST_COUNT)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Record each request transfer, then check any outcome in the same cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				tracker.note_request(item);
			if (result_valid)
				tracker.check_outcome(result);
		end
	end

	// Abort when nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	function automatic spdq_pkg::in_item_t build_request(logic op, logic [1:0] sev,
		logic [15:0] tag, logic [1:0] dest);
		spdq_pkg::in_item_t req;
		req.op          = op;
		req.severity    = sev;
		req.tag         = tag;
		req.destination = dest;
		return req;
	endfunction

	function automatic spdq_pkg::in_item_t random_request(int push_pct);
		spdq_pkg::in_item_t req;
		req.op          = ($urandom_range(99) < push_pct) ? spdq_pkg::OP_PUSH : spdq_pkg::OP_POP;
		req.severity    = 2'($urandom_range(3));
		req.tag         = 16'($urandom_range(16'hFFFF));
		req.destination = 2'($urandom_range(3));
		return req;
	endfunction

	// Hold start high until the request transfers, with random idle cycles ahead of it
	task automatic send_request(spdq_pkg::in_item_t req);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= req;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Drop start and wait until every predicted outcome has been delivered
	task automatic wait_until_settled();
		start <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_active(logic [2:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		tracker.set_active(value);
	endtask

	initial begin
		logic [2:0] active_plan[6];
		int         push_pct;
		active_plan = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd3, 3'd4};
		gap_pct = 0;
		start     <= 1'b0;
		item      <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pops, severity ordering, inactive destinations at reset value
		send_request(build_request(spdq_pkg::OP_POP, 2'd0, 16'h0000, 2'd0));
		send_request(build_request(spdq_pkg::OP_POP, 2'd3, 16'hFFFF, 2'd3));
		send_request(build_request(spdq_pkg::OP_PUSH, 2'd0, 16'h0000, 2'd3));
		send_request(build_request(spdq_pkg::OP_PUSH, 2'd1, 16'hFFFF, 2'd0));
		send_request(build_request(spdq_pkg::OP_PUSH, 2'd3, 16'hA5A5, 2'd2));
		send_request(build_request(spdq_pkg::OP_PUSH, 2'd2, 16'h5A5A, 2'd1));
		send_request(build_request(spdq_pkg::OP_PUSH, 2'd3, 16'h1234, 2'd0));
		send_request(build_request(spdq_pkg::OP_PUSH, 2'd1, 16'h8001, 2'd0));
		send_request(build_request(spdq_pkg::OP_POP, 2'd3, 16'hFFFF, 2'd2));
		send_request(build_request(spdq_pkg::OP_POP, 2'd0, 16'h0000, 2'd3));
		send_request(build_request(spdq_pkg::OP_POP, 2'd0, 16'h0000, 2'd0));
		send_request(build_request(spdq_pkg::OP_POP, 2'd0, 16'h0000, 2'd1));
		send_request(build_request(spdq_pkg::OP_POP, 2'd0, 16'h0000, 2'd1));
		send_request(build_request(spdq_pkg::OP_POP, 2'd0, 16'h0000, 2'd0));
		send_request(build_request(spdq_pkg::OP_POP, 2'd0, 16'h0000, 2'd0));
		send_request(build_request(spdq_pkg::OP_POP, 2'd0, 16'h0000, 2'd1));
		send_request(build_request(spdq_pkg::OP_POP, 2'd0, 16'h0000, 2'd1));
		wait_until_settled();

		// Random phases: new active limit each time, rotating idle patterns
		foreach (active_plan[p]) begin
			write_active(active_plan[p]);
			case (p % 3)
				0: gap_pct = 0;
				1: gap_pct = 85;
				default: gap_pct = 10;
			endcase
			push_pct = 50;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Swing the push bias so the queue fills up and drains out
				if (n % 40 == 0) begin
					case ($urandom_range(2))
						0: push_pct = 85;
						1: push_pct = 50;
						default: push_pct = 15;
					endcase
				end
				send_request(random_request(push_pct));
			end
			wait_until_settled();
		end

		repeat (6) @(posedge clk);
		tracker.flag_leftovers();
		if (tracker.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
